// File: sv/eraf_pkg.sv
// Shared types and constants for the edge ring alpha floor unit.
package eraf_pkg;

  localparam int unsigned CfgDimW    = 13;
  localparam int unsigned CfgGrabW   = 8;
  localparam int unsigned PixelW     = 32;
  localparam int unsigned ApbAddrW   = 4;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [PixelW-1:0]   FloorPixel   = 32'h0100_0000;

  localparam logic [CfgDimW-1:0]  WidthReset   = 13'd640;
  localparam logic [CfgDimW-1:0]  HeightReset  = 13'd480;
  localparam logic [CfgGrabW-1:0] GrabReset    = 8'd8;
  localparam logic                CircleReset  = 1'b0;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;
  localparam logic [1:0] RegGrabMargin  = 2'd2;
  localparam logic [1:0] RegCircleMode  = 2'd3;

  typedef struct packed {
    logic [PixelW-1:0] pixel_in;
    logic              frame_start;
  } in_word_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel_out;
    logic              frame_end;
  } out_word_t;

endpackage

// File: sv/eraf_regs.sv
// Configuration registers behind the APB-style port, with frame size clamping.
module eraf_regs
  import eraf_pkg::*;
#(
  parameter int unsigned MaxDim = 4096,
  parameter int unsigned DimW   = $clog2(MaxDim + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic [DimW-1:0]     width_o,
  output logic [DimW-1:0]     height_o,
  output logic [CfgGrabW-1:0] grab_o,
  output logic                circle_o
);

  localparam int unsigned CmpW = (DimW > CfgDimW) ? DimW : CfgDimW;

  logic [CfgDimW-1:0]  width_q, height_q;
  logic [CfgGrabW-1:0] grab_q;
  logic                circle_q;
  logic                wr_en;
  logic [1:0]          reg_idx;
  logic [CmpW-1:0]     width_ext, height_ext;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      grab_q   <= GrabReset;
      circle_q <= CircleReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegFrameWidth:  width_q  <= pwdata[CfgDimW-1:0];
        RegFrameHeight: height_q <= pwdata[CfgDimW-1:0];
        RegGrabMargin:  grab_q   <= pwdata[CfgGrabW-1:0];
        RegCircleMode:  circle_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegFrameWidth:  prdata = ApbDataW'(width_q);
      RegFrameHeight: prdata = ApbDataW'(height_q);
      RegGrabMargin:  prdata = ApbDataW'(grab_q);
      RegCircleMode:  prdata = ApbDataW'(circle_q);
      default:        prdata = '0;
    endcase
  end

  // zero counts as one, anything above the limit as the limit
  assign width_ext  = CmpW'(width_q);
  assign height_ext = CmpW'(height_q);

  always_comb begin
    if (width_ext == '0) begin
      width_o = DimW'(1);
    end else if (width_ext > CmpW'(MaxDim)) begin
      width_o = DimW'(MaxDim);
    end else begin
      width_o = DimW'(width_ext);
    end
    if (height_ext == '0) begin
      height_o = DimW'(1);
    end else if (height_ext > CmpW'(MaxDim)) begin
      height_o = DimW'(MaxDim);
    end else begin
      height_o = DimW'(height_ext);
    end
  end

  assign grab_o   = grab_q;
  assign circle_o = circle_q;

endmodule

// File: sv/eraf_pos.sv
// Column and row counters that place each accepted word in the frame.
module eraf_pos
  import eraf_pkg::*;
#(
  parameter int unsigned MaxDim = 4096,
  parameter int unsigned DimW   = $clog2(MaxDim + 1),
  parameter int unsigned PosW   = $clog2(MaxDim)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            frame_start_i,
  input  logic [DimW-1:0] width_i,
  input  logic [DimW-1:0] height_i,
  output logic [PosW-1:0] col_o,
  output logic [PosW-1:0] row_o,
  output logic            frame_end_o
);

  logic [PosW-1:0] col_q, col_d, row_q, row_d;
  logic            last_col, last_row;

  // frame start clears the position before this word is placed
  assign col_o = frame_start_i ? '0 : col_q;
  assign row_o = frame_start_i ? '0 : row_q;

  // at or past the last column counts as the last one
  assign last_col = ((DimW+1)'(col_o) + (DimW+1)'(1)) >= (DimW+1)'(width_i);
  assign last_row = ((DimW+1)'(row_o) + (DimW+1)'(1)) >= (DimW+1)'(height_i);
  assign frame_end_o = last_col && last_row;

  always_comb begin
    col_d = col_o + PosW'(1);
    row_d = row_o;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_o + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// File: sv/eraf_zone.sv
// Grab zone test (annulus or border band) and the transparent pixel floor.
module eraf_zone
  import eraf_pkg::*;
#(
  parameter int unsigned MaxDim = 4096,
  parameter int unsigned DimW   = $clog2(MaxDim + 1),
  parameter int unsigned PosW   = $clog2(MaxDim)
) (
  input  logic [PosW-1:0]     col_i,
  input  logic [PosW-1:0]     row_i,
  input  logic [PixelW-1:0]   pixel_i,
  input  logic [DimW-1:0]     width_i,
  input  logic [DimW-1:0]     height_i,
  input  logic [CfgGrabW-1:0] grab_i,
  input  logic                circle_i,
  output logic [PixelW-1:0]   pixel_o
);

  localparam int unsigned SW = DimW + 2;   // signed doubled offset
  localparam int unsigned RW = DimW + 2;   // radius in doubled units
  localparam int unsigned QW = 2 * SW + 1; // squared distance sum

  logic signed [SW-1:0]   dx, dy;
  logic signed [2*SW-1:0] dx_sq, dy_sq;
  logic [QW-1:0]          dist_sq, outer_sq, inner_sq;
  logic [DimW-1:0]        min_dim;
  logic [RW-1:0]          grab2, outer, inner;
  logic                   in_circle, in_rect, in_zone;

  // doubled coordinates keep the pixel center on the integer grid
  assign dx = $signed(SW'({col_i, 1'b1})) - $signed(SW'(width_i));
  assign dy = $signed(SW'({row_i, 1'b1})) - $signed(SW'(height_i));
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign dist_sq = QW'($unsigned(dx_sq)) + QW'($unsigned(dy_sq));

  assign min_dim = (width_i < height_i) ? width_i : height_i;
  assign grab2   = RW'({grab_i, 1'b0});
  assign outer   = RW'(min_dim) + grab2;
  // floor the inner radius at zero
  assign inner   = (RW'(min_dim) > grab2) ? RW'(min_dim) - grab2 : '0;
  assign outer_sq = QW'(outer) * QW'(outer);
  assign inner_sq = QW'(inner) * QW'(inner);

  assign in_circle = (dist_sq >= inner_sq) && (dist_sq <= outer_sq);

  assign in_rect = ((DimW+1)'(col_i) < (DimW+1)'(grab_i))
                || ((DimW+1)'(row_i) < (DimW+1)'(grab_i))
                || (((DimW+1)'(col_i) + (DimW+1)'(grab_i)) >= (DimW+1)'(width_i))
                || (((DimW+1)'(row_i) + (DimW+1)'(grab_i)) >= (DimW+1)'(height_i));

  assign in_zone = circle_i ? in_circle : in_rect;

  assign pixel_o = (in_zone && (pixel_i[31:24] == 8'h00)) ? FloorPixel : pixel_i;

endmodule

// File: sv/edge_ring_alpha_floor_unit.sv
// Edge ring alpha floor unit: top level with the two-stage word pipeline.
//
// Takes one premultiplied ARGB word per clock in raster order while
// in_stall_o is low, and returns one word per clock while out_stall_i is low.
// The counters place each word at accept time; the next stage squares the
// doubled offsets (two multipliers of DimW+2 bits) and compares them against
// the ring radii, or tests the border band, then the result register holds
// the word. A word with zero alpha inside the grab zone leaves as 0x01000000.
// A stalled result blocks input only after the middle stage takes one more.
// Configuration writes are only to be made while no word is in flight.
module edge_ring_alpha_floor_unit
  import eraf_pkg::*;
#(
  parameter int unsigned MaxDim = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_data_o
);

  localparam int unsigned DimW = $clog2(MaxDim + 1);
  localparam int unsigned PosW = $clog2(MaxDim);

  logic [DimW-1:0]     width, height;
  logic [CfgGrabW-1:0] grab;
  logic                circle;

  logic                in_accept, mid_move, out_free;
  logic [PosW-1:0]     col, row;
  logic                frame_end;

  logic                mid_valid_q;
  logic [PosW-1:0]     mid_col_q, mid_row_q;
  logic [PixelW-1:0]   mid_pixel_q;
  logic                mid_end_q;
  logic [PixelW-1:0]   zone_pixel;

  logic                out_valid_q;
  out_word_t           out_word_q;

  eraf_regs #(
    .MaxDim (MaxDim),
    .DimW   (DimW)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .width_o  (width),
    .height_o (height),
    .grab_o   (grab),
    .circle_o (circle)
  );

  // the result register frees when empty or taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mid_move   = mid_valid_q && out_free;
  assign in_stall_o = mid_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  eraf_pos #(
    .MaxDim (MaxDim),
    .DimW   (DimW),
    .PosW   (PosW)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (in_accept),
    .frame_start_i (in_data_i.frame_start),
    .width_i       (width),
    .height_i      (height),
    .col_o         (col),
    .row_o         (row),
    .frame_end_o   (frame_end)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      mid_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mid_col_q   <= col;
      mid_row_q   <= row;
      mid_pixel_q <= in_data_i.pixel_in;
      mid_end_q   <= frame_end;
    end
  end

  eraf_zone #(
    .MaxDim (MaxDim),
    .DimW   (DimW),
    .PosW   (PosW)
  ) u_zone (
    .col_i    (mid_col_q),
    .row_i    (mid_row_q),
    .pixel_i  (mid_pixel_q),
    .width_i  (width),
    .height_i (height),
    .grab_i   (grab),
    .circle_i (circle),
    .pixel_o  (zone_pixel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_move) begin
      out_word_q.pixel_out <= zone_pixel;
      out_word_q.frame_end <= mid_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule
